[rtl/core/point_gravity_source_update_assert.svh]
// Assertion macros used by the point gravity source queue
`ifndef POINT_GRAVITY_SOURCE_UPDATE_ASSERT_SVH
`define POINT_GRAVITY_SOURCE_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PGS_ASSERT_IMP(label, c, r, ante, cons) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("pgs assertion failed");
// next-cycle implication
`define PGS_ASSERT_NXT(label, c, r, ante, cons) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("pgs assertion failed");
`else
`define PGS_ASSERT_IMP(label, c, r, ante, cons)
`define PGS_ASSERT_NXT(label, c, r, ante, cons)
`endif
`endif

[rtl/core/pgs_pkg.sv]
// Types and constants of the point gravity source kernel
`default_nettype none
package pgs_pkg;

  localparam int WORD_W  = 32;  // signed Q.F words
  localparam int UREG_W  = 31;  // unsigned Q.F words
  localparam int MAG_W   = 33;  // |pos - center|
  localparam int SQ_W    = 66;  // sum of squares plus rs^2
  localparam int ROOT_W  = 33;  // floor(sqrt)
  localparam int SPLIT_W = 33;  // radicand split for s*r
  localparam int DEN_W   = 99;  // s*r
  localparam int GMDT_W  = 62;  // grav_mass*time_step
  localparam int HALF_W  = 31;  // 62-bit operand halves
  localparam int KICK_W  = 62;
  localparam int ACC_W   = 96;  // final products and sums

  localparam logic [KICK_W-1:0] KICK_CAP = '1;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_MASS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTEN_RADIUS = 3'd5;

  typedef struct packed {
    logic [UREG_W-1:0]        grav_mass;
    logic [UREG_W-1:0]        time_step;
    logic signed [WORD_W-1:0] center_x;
    logic signed [WORD_W-1:0] center_y;
    logic signed [WORD_W-1:0] center_z;
    logic [UREG_W-1:0]        soften_radius;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic [UREG_W-1:0]        density;
    logic signed [WORD_W-1:0] mom_x;
    logic signed [WORD_W-1:0] mom_y;
    logic signed [WORD_W-1:0] mom_z;
    logic signed [WORD_W-1:0] energy;
  } cell_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_mom_x;
    logic signed [WORD_W-1:0] new_mom_y;
    logic signed [WORD_W-1:0] new_mom_z;
    logic signed [WORD_W-1:0] new_energy;
    logic                     saturated;
  } result_t;

  // classified cell as queued between front and back
  typedef struct packed {
    logic [2:0][MAG_W-1:0]    mag;   // |offset| per axis
    logic [2:0]               kneg;  // kick is negative (offset > 0)
    logic [2:0][WORD_W-1:0]   mom;
    logic signed [WORD_W-1:0] energy;
    logic [UREG_W-1:0]        density;
  } work_t;

endpackage
`default_nettype wire

[rtl/core/pgs_chan.sv]
// Valid/ready stream interface
`default_nettype none
interface pgs_chan #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/pgs_front.sv]
// Front end: accepts cells, forms per-axis offset magnitude and kick sign
`default_nettype none
module pgs_front import pgs_pkg::*; (
  input  cfg_t          cfg,
  pgs_chan.sink         grid_cell,
  output logic          push_valid,
  output work_t         push_data,
  input  logic          push_ready
);

  logic [2:0][WORD_W-1:0] pos;
  logic [2:0][WORD_W-1:0] ctr;
  logic [2:0][MAG_W-1:0]  diff;

  assign pos = {grid_cell.data.pos_z, grid_cell.data.pos_y, grid_cell.data.pos_x};
  assign ctr = {cfg.center_z, cfg.center_y, cfg.center_x};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = MAG_W'($signed(pos[a])) - MAG_W'($signed(ctr[a]));
      push_data.mag[a]  = diff[a][MAG_W-1] ? (~diff[a] + 1'b1) : diff[a];
      push_data.kneg[a] = !diff[a][MAG_W-1] && (diff[a] != '0);
    end
    push_data.mom     = {grid_cell.data.mom_z, grid_cell.data.mom_y, grid_cell.data.mom_x};
    push_data.energy  = grid_cell.data.energy;
    push_data.density = grid_cell.data.density;
  end

  assign push_valid      = grid_cell.valid;
  assign grid_cell.ready = push_ready;

endmodule
`default_nettype wire

[rtl/core/pgs_queue.sv]
// Small FIFO decoupling front and back
`default_nettype none
`include "point_gravity_source_update_assert.svh"
module pgs_queue #(
  parameter int  DEPTH  = 2,
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_data,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_data,
  input  logic  pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  cnt;
  logic              push;
  logic              pop;

  assign push_ready = (cnt != CNT_W'(DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  `PGS_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(DEPTH))
  `PGS_ASSERT_NXT(a_cnt_inc, clk, rst, push && !pop, cnt == $past(cnt) + 1'b1)
  `PGS_ASSERT_NXT(a_cnt_dec, clk, rst, pop && !push, cnt == $past(cnt) - 1'b1)

endmodule
`default_nettype wire

[rtl/core/pgs_sqrt.sv]
// Pipelined integer square root, one root bit per stage
`default_nettype none
module pgs_sqrt #(
  parameter int  IN_W  = 66,
  parameter type tag_t = logic
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [IN_W-1:0]         radicand,
  input  tag_t                    in_tag,
  output logic                    out_valid,
  output logic [(IN_W+1)/2-1:0]   root,
  output tag_t                    out_tag
);

  localparam int RW    = (IN_W + 1) / 2;
  localparam int REM_W = IN_W + 1;

  logic             vld_q  [RW];
  logic [REM_W-1:0] rem_q  [RW];
  logic [RW-1:0]    root_q [RW];
  tag_t             tag_q  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int B = RW - 1 - i;  // root bit decided here
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] trial;
    logic [RW-1:0]    root_in;
    tag_t             tag_in;
    logic             v_in;

    if (i == 0) begin : g_first
      assign rem_in  = REM_W'(radicand);
      assign root_in = '0;
      assign tag_in  = in_tag;
      assign v_in    = in_valid;
    end else begin : g_rest
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign tag_in  = tag_q[i-1];
      assign v_in    = vld_q[i-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (REM_W'(root_in) << (B + 1)) | (REM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[i] <= tag_in;
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= root_in | (RW'(1) << B);
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
      end
    end
  end

  assign out_valid = vld_q[RW-1];
  assign root      = root_q[RW-1];
  assign out_tag   = tag_q[RW-1];

endmodule
`default_nettype wire

[rtl/core/pgs_div.sv]
// Pipelined restoring divider, shared divisor, one quotient bit per stage
`default_nettype none
module pgs_div #(
  parameter int  LANES = 3,
  parameter int  NUM_W = 111,
  parameter int  DEN_W = 99,
  parameter int  QUO_W = 62,
  parameter type tag_t = logic
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [DEN_W-1:0]            den,
  input  tag_t                        in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][QUO_W-1:0] quo,
  output logic [LANES-1:0]            ovf,
  output tag_t                        out_tag
);

  localparam int REM_W  = DEN_W + 1;
  localparam int HI_W   = NUM_W - QUO_W;
  localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int STAGES = QUO_W + 1;

  logic                        vld_q [STAGES];
  tag_t                        tag_q [STAGES];
  logic [DEN_W-1:0]            den_q [STAGES];
  logic [LANES-1:0][REM_W-1:0] rem_q [STAGES];
  logic [LANES-1:0][QUO_W-1:0] lo_q  [STAGES];
  logic [LANES-1:0][QUO_W-1:0] q_q   [STAGES];
  logic [LANES-1:0]            ovf_q [STAGES];

  // stage 0: quotient would not fit when the top part already reaches den
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_q[0] <= in_tag;
      den_q[0] <= den;
      for (int l = 0; l < LANES; l++) begin
        ovf_q[0][l] <= CMP_W'(num[l][NUM_W-1:QUO_W]) >= CMP_W'(den);
        rem_q[0][l] <= REM_W'(num[l][NUM_W-1:QUO_W]);
        lo_q[0][l]  <= num[l][QUO_W-1:0];
        q_q[0][l]   <= '0;
      end
    end
  end

  for (genvar s = 1; s < STAGES; s++) begin : g_stage
    logic [LANES-1:0][REM_W-1:0] rem_nx;
    logic [LANES-1:0][QUO_W-1:0] q_nx;
    logic [REM_W-1:0]            trial [LANES];
    logic [LANES-1:0]            take;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]  = {rem_q[s-1][l][REM_W-2:0], lo_q[s-1][l][QUO_W-1]};
        take[l]   = trial[l] >= REM_W'(den_q[s-1]);
        rem_nx[l] = take[l] ? trial[l] - REM_W'(den_q[s-1]) : trial[l];
        q_nx[l]   = {q_q[s-1][l][QUO_W-2:0], take[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[s] <= tag_q[s-1];
        den_q[s] <= den_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        rem_q[s] <= rem_nx;
        q_q[s]   <= q_nx;
        for (int l = 0; l < LANES; l++) begin
          lo_q[s][l] <= lo_q[s-1][l] << 1;
        end
      end
    end
  end

  assign out_valid = vld_q[STAGES-1];
  assign quo       = q_q[STAGES-1];
  assign ovf       = ovf_q[STAGES-1];
  assign out_tag   = tag_q[STAGES-1];

endmodule
`default_nettype wire

[rtl/core/pgs_back.sv]
// Back end: distance, root, divide, kick and saturating updates
`default_nettype none
module pgs_back import pgs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    pop_valid,
  input  work_t   pop_data,
  output logic    pop_ready,
  pgs_chan.source result
);

  localparam int NUM_W = GMDT_W + MAG_W + FRAC_BITS;
  localparam int PS_W  = 2 * SPLIT_W;
  localparam int PN_W  = HALF_W + MAG_W;
  localparam int PM_W  = WORD_W + HALF_W;
  localparam int PD_W  = UREG_W + HALF_W;

  typedef struct packed {
    work_t           w;
    logic [SQ_W-1:0] s;
  } sq_tag_t;

  typedef struct packed {
    work_t w;
    logic  dzero;
  } dv_tag_t;

  function automatic logic [WORD_W:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-WORD_W:0] top;
    top = v[ACC_W-1:WORD_W-1];
    if ((&top) || !(|top)) begin
      return {1'b0, v[WORD_W-1:0]};
    end else if (v[ACC_W-1]) begin
      return {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  logic adv;
  assign adv       = !result.valid || result.ready;
  assign pop_ready = adv;

  // GM*dt changes only with configuration
  logic [GMDT_W-1:0] gmdt;
  always_ff @(posedge clk) begin
    gmdt <= GMDT_W'(cfg.grav_mass) * GMDT_W'(cfg.time_step);
  end

  // A: squares
  logic                  va;
  work_t                 wa;
  logic [2:0][SQ_W-1:0]  sqa;
  logic [SQ_W-1:0]       rs2a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wa   <= pop_data;
      rs2a <= SQ_W'(cfg.soften_radius) * SQ_W'(cfg.soften_radius);
      for (int a = 0; a < 3; a++) begin
        sqa[a] <= SQ_W'(pop_data.mag[a]) * SQ_W'(pop_data.mag[a]);
      end
    end
  end

  // B: softened r^2
  logic            vb;
  work_t           wb;
  logic [SQ_W-1:0] sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wb <= wa;
      sb <= sqa[0] + sqa[1] + sqa[2] + rs2a;
    end
  end

  // root
  sq_tag_t           sq_in;
  sq_tag_t           sq_out;
  logic              vr;
  logic [ROOT_W-1:0] root_r;

  assign sq_in.w = wb;
  assign sq_in.s = sb;

  pgs_sqrt #(
    .IN_W  (SQ_W),
    .tag_t (sq_tag_t)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vb),
    .radicand  (sb),
    .in_tag    (sq_in),
    .out_valid (vr),
    .root      (root_r),
    .out_tag   (sq_out)
  );

  // C: partial products of s*r and GMdt*|d|
  logic                 vc;
  work_t                wc;
  logic                 dzc;
  logic [PS_W-1:0]      pss_lo;
  logic [PS_W-1:0]      pss_hi;
  logic [2:0][PN_W-1:0] pn_lo;
  logic [2:0][PN_W-1:0] pn_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wc     <= sq_out.w;
      dzc    <= (sq_out.s == '0);
      pss_lo <= PS_W'(sq_out.s[SPLIT_W-1:0]) * PS_W'(root_r);
      pss_hi <= PS_W'(sq_out.s[SQ_W-1:SPLIT_W]) * PS_W'(root_r);
      for (int a = 0; a < 3; a++) begin
        pn_lo[a] <= PN_W'(gmdt[HALF_W-1:0]) * PN_W'(sq_out.w.mag[a]);
        pn_hi[a] <= PN_W'(gmdt[GMDT_W-1:HALF_W]) * PN_W'(sq_out.w.mag[a]);
      end
    end
  end

  // D: divisor and numerators
  logic                  vd;
  dv_tag_t               dtag_d;
  logic [DEN_W-1:0]      den_d;
  logic [2:0][NUM_W-1:0] num_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dtag_d.w     <= wc;
      dtag_d.dzero <= dzc;
      den_d        <= DEN_W'(pss_lo) + (DEN_W'(pss_hi) << SPLIT_W);
      for (int a = 0; a < 3; a++) begin
        num_d[a] <= (NUM_W'(pn_lo[a]) + (NUM_W'(pn_hi[a]) << HALF_W)) << FRAC_BITS;
      end
    end
  end

  logic                   vq;
  logic [2:0][KICK_W-1:0] quo;
  logic [2:0]             ovf;
  dv_tag_t                dtag_q;

  pgs_div #(
    .LANES (3),
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (KICK_W),
    .tag_t (dv_tag_t)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vd),
    .num       (num_d),
    .den       (den_d),
    .in_tag    (dtag_d),
    .out_valid (vq),
    .quo       (quo),
    .ovf       (ovf),
    .out_tag   (dtag_q)
  );

  // E: clamp kick, partial products with momentum and density
  logic [2:0][KICK_W-1:0] kick;
  logic [2:0][WORD_W-1:0] mmag;
  logic                   kflag;

  always_comb begin
    kflag = !dtag_q.dzero && (|ovf);
    for (int a = 0; a < 3; a++) begin
      if (dtag_q.dzero) begin
        kick[a] = '0;
      end else if (ovf[a]) begin
        kick[a] = KICK_CAP;
      end else begin
        kick[a] = quo[a];
      end
      mmag[a] = dtag_q.w.mom[a][WORD_W-1] ? (~dtag_q.w.mom[a] + 1'b1) : dtag_q.w.mom[a];
    end
  end

  logic                 ve;
  work_t                we;
  logic                 kfe;
  logic [2:0]           esn;
  logic [2:0][PM_W-1:0] pem_lo;
  logic [2:0][PM_W-1:0] pem_hi;
  logic [2:0][PD_W-1:0] ped_lo;
  logic [2:0][PD_W-1:0] ped_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (adv) begin
      ve <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      we  <= dtag_q.w;
      kfe <= kflag;
      for (int a = 0; a < 3; a++) begin
        esn[a]    <= dtag_q.w.mom[a][WORD_W-1] != dtag_q.w.kneg[a];
        pem_lo[a] <= PM_W'(mmag[a]) * PM_W'(kick[a][HALF_W-1:0]);
        pem_hi[a] <= PM_W'(mmag[a]) * PM_W'(kick[a][KICK_W-1:HALF_W]);
        ped_lo[a] <= PD_W'(dtag_q.w.density) * PD_W'(kick[a][HALF_W-1:0]);
        ped_hi[a] <= PD_W'(dtag_q.w.density) * PD_W'(kick[a][KICK_W-1:HALF_W]);
      end
    end
  end

  // F: signed products, energy sum
  logic [2:0][ACC_W-1:0] pm;
  logic [2:0][ACC_W-1:0] pd;
  logic [2:0][ACC_W-1:0] md;
  logic [ACC_W-1:0]      esum;

  always_comb begin
    esum = '0;
    for (int a = 0; a < 3; a++) begin
      pm[a] = ACC_W'(pem_lo[a]) + (ACC_W'(pem_hi[a]) << HALF_W);
      pd[a] = ACC_W'(ped_lo[a]) + (ACC_W'(ped_hi[a]) << HALF_W);
      esum  = esum + (esn[a] ? (~pm[a] + 1'b1) : pm[a]);
      md[a] = we.kneg[a] ? (~pd[a] + 1'b1) : pd[a];
    end
  end

  logic                  vf;
  work_t                 wf;
  logic                  kff;
  logic [ACC_W-1:0]      esum_f;
  logic [2:0][ACC_W-1:0] md_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (adv) begin
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wf     <= we;
      kff    <= kfe;
      esum_f <= esum;
      md_f   <= md;
    end
  end

  // G: scale back, add old values, saturate into the output register
  logic signed [ACC_W-1:0] ev;
  logic signed [ACC_W-1:0] mv [3];
  logic [WORD_W:0]         es;
  logic [WORD_W:0]         ms [3];

  always_comb begin
    ev = ($signed(esum_f) >>> FRAC_BITS) + ACC_W'($signed(wf.energy));
    es = sat_word(ev);
    for (int a = 0; a < 3; a++) begin
      mv[a] = ($signed(md_f[a]) >>> FRAC_BITS) + ACC_W'($signed(wf.mom[a]));
      ms[a] = sat_word(mv[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.data.new_energy <= es[WORD_W-1:0];
      result.data.new_mom_x  <= ms[0][WORD_W-1:0];
      result.data.new_mom_y  <= ms[1][WORD_W-1:0];
      result.data.new_mom_z  <= ms[2][WORD_W-1:0];
      result.data.saturated  <= kff | es[WORD_W] | ms[0][WORD_W] | ms[1][WORD_W]
                                | ms[2][WORD_W];
    end
  end

endmodule
`default_nettype wire

[rtl/core/point_gravity_source_update.sv]
// Top level of the softened point-mass gravity kick kernel
//
//  channel    | dir | handshake       | payload
//  -----------+-----+-----------------+-------------------------------------
//  grid_cell  | in  | valid/ready     | pos_x/y/z, density, mom_x/y/z, energy
//  result     | out | valid/ready     | new_mom_x/y/z, new_energy, saturated
//  wr_*       | in  | wr_en strobe    | wr_index, wr_data (6 registers)
//
// One cell per cycle while results are taken; the delay to a result is set
// mostly by the 33-stage square root and the 63-stage divider.
// The front classifies a cell and pushes it into a 2-entry queue; the back
// pipeline advances as one unit whenever its output register is free.
// A stalled result holds the whole back pipeline; the queue keeps the
// input side taking transactions until it fills.
// Synchronous reset clears valids, queue pointers and the registers
// (soften_radius resets to 1.0).
`default_nettype none
module point_gravity_source_update import pgs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  pgs_chan.sink                grid_cell,
  pgs_chan.source              result
);

  localparam logic [UREG_W-1:0] SOFTEN_ONE = UREG_W'(1) << FRAC_BITS;

  cfg_t  cfg;
  logic  push_valid;
  work_t push_data;
  logic  push_ready;
  logic  pop_valid;
  work_t pop_data;
  logic  pop_ready;

  // configuration registers; out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grav_mass     <= '0;
      cfg.time_step     <= '0;
      cfg.center_x      <= '0;
      cfg.center_y      <= '0;
      cfg.center_z      <= '0;
      cfg.soften_radius <= SOFTEN_ONE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GRAV_MASS:     cfg.grav_mass     <= wr_data[UREG_W-1:0];
        REG_TIME_STEP:     cfg.time_step     <= wr_data[UREG_W-1:0];
        REG_CENTER_X:      cfg.center_x      <= wr_data;
        REG_CENTER_Y:      cfg.center_y      <= wr_data;
        REG_CENTER_Z:      cfg.center_z      <= wr_data;
        REG_SOFTEN_RADIUS: cfg.soften_radius <= wr_data[UREG_W-1:0];
        default: ;
      endcase
    end
  end

  // offsets and kick signs
  pgs_front u_front (
    .cfg        (cfg),
    .grid_cell  (grid_cell),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  pgs_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (work_t)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // arithmetic pipeline ending in the result register
  pgs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule
`default_nettype wire
